@@ hdl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the expression evaluator
// Token and status codes, stack sizing, sequencer states and the ALU ports.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    TK_NUM   = 3'd0,
    TK_ADD   = 3'd1,
    TK_SUB   = 3'd2,
    TK_MUL   = 3'd3,
    TK_DIV   = 3'd4,
    TK_OPEN  = 3'd5,
    TK_CLOSE = 3'd6,
    TK_END   = 3'd7
  } token_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIVZERO  = 3'd1,
    ST_PAREN    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_MISSING  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_ALU,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    token_e      code;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } alu_rsp_t;

endpackage

@@ hdl/iee_alu.sv @@
// ----------------------------------------------------------------------------
// iee_alu: shared arithmetic unit
// Add, subtract and multiply registered; signed division bit-serially.
// ----------------------------------------------------------------------------
module iee_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iee_pkg::alu_req_t req_i,
  output iee_pkg::alu_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [31:0] res_q, res_d;
  logic [32:0] trial;
  logic [31:0] abs_a, abs_b, quo_f;

  assign abs_a = req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
  assign abs_b = req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, div_q};
  assign quo_f = {quo_q[30:0], ~trial[32]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      case (req_i.code)
        iee_pkg::TK_ADD: begin
          res_d  = req_i.a + req_i.b;
          done_d = 1'b1;
        end
        iee_pkg::TK_SUB: begin
          res_d  = req_i.a - req_i.b;
          done_d = 1'b1;
        end
        iee_pkg::TK_MUL: begin
          res_d  = req_i.a * req_i.b;
          done_d = 1'b1;
        end
        default: begin
          busy_d = 1'b1;
          cnt_d  = 6'd0;
          quo_d  = abs_a;
          rem_d  = '0;
          div_d  = abs_b;
          neg_d  = req_i.a[31] ^ req_i.b[31];
        end
      endcase
    end else if (busy_q) begin
      // Restoring division: one quotient bit per cycle.
      quo_d = quo_f;
      rem_d = trial[32] ? {rem_q[31:0], quo_q[31]} : trial;
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (~quo_f + 32'd1) : quo_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

@@ hdl/infix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator: two-stack operator-precedence evaluator
// ----------------------------------------------------------------------------
// One word per token on the input channel: op_i gives its kind, number_value_i
// the operand for a number. An operator goes through a decision and, for each
// reduction it triggers, through the ALU (add, subtract or multiply directly, a
// division through the bit-serial divider in iee_alu) and a write-back of the
// result. in_stall_o is high while a token is in work.
// When '=' closes the expression, or on an error, one result word appears on
// result_value_o and status_o with out_valid_o; the stacks are then reset to
// the bottom marker. While the receiver stalls, the result holds and no new
// token is taken. Reset empties both stacks; the stack memories need no
// clearing since only written entries are read.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] number_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o
);

  localparam int unsigned Depth = iee_pkg::StackDepth;

  iee_pkg::state_e   state_q, state_d;
  iee_pkg::token_e   tok_q;
  logic [iee_pkg::CntW-1:0] ocnt_q, ocnt_d, vcnt_q, vcnt_d;
  logic [2:0]        ostk [Depth];
  logic [31:0]       vstk [Depth];
  logic [2:0]        top_q;
  logic [31:0]       va_q, vb_q;
  logic [31:0]       res_q, res_d;
  logic [2:0]        sts_q, sts_d;
  logic              push_o, push_v, wr_res, ld_tok;
  logic [31:0]       v_wdata;
  iee_pkg::alu_req_t req;
  iee_pkg::alu_rsp_t rsp;
  logic              push, reduce, emit;
  logic [2:0]        estat;
  logic [31:0]       evalue;
  logic [iee_pkg::PtrW-1:0] otop, vtop;

  iee_alu u_alu (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign otop = iee_pkg::PtrW'(ocnt_q - 1'b1);
  assign vtop = iee_pkg::PtrW'(vcnt_q - 1'b1);

  // Stacks: registered reads of the tops; the value stack has two write ports.
  // The reduction result lands at the new top in the same edge that reads it,
  // so the top read takes the result directly.
  always_ff @(posedge clk_i) begin
    if (push_o) ostk[iee_pkg::PtrW'(ocnt_q)] <= tok_q;
    if (push_v) vstk[iee_pkg::PtrW'(vcnt_q)] <= v_wdata;
    if (wr_res) vstk[vtop] <= rsp.res;
    if (ld_tok) tok_q <= iee_pkg::token_e'(op_i);
    top_q <= (ocnt_q == 1) ? 3'(iee_pkg::TK_END) : ostk[otop];
    vb_q  <= wr_res ? rsp.res : vstk[vtop];
    va_q  <= vstk[iee_pkg::PtrW'(vcnt_q - 2'd2)];
    res_q <= res_d;
    sts_q <= sts_d;
  end

  // Precedence decision on the registered stack top.
  always_comb begin
    push   = 1'b0;
    reduce = 1'b0;
    emit   = 1'b0;
    estat  = 3'(iee_pkg::ST_OK);
    evalue = '0;
    case (top_q)
      3'(iee_pkg::TK_END): begin
        if (tok_q == iee_pkg::TK_CLOSE) begin
          emit = 1'b1; estat = 3'(iee_pkg::ST_PAREN);
        end else if (tok_q == iee_pkg::TK_END) begin
          emit = 1'b1;
          if (vcnt_q != 1) estat = 3'(iee_pkg::ST_MISSING);
          else evalue = vb_q;
        end else begin
          push = 1'b1;
        end
      end
      3'(iee_pkg::TK_OPEN): begin
        if (tok_q == iee_pkg::TK_END) begin
          emit = 1'b1; estat = 3'(iee_pkg::ST_PAREN);
        end else begin
          push = (tok_q != iee_pkg::TK_CLOSE);
        end
      end
      3'(iee_pkg::TK_ADD), 3'(iee_pkg::TK_SUB): begin
        push = tok_q inside {iee_pkg::TK_MUL, iee_pkg::TK_DIV, iee_pkg::TK_OPEN};
        reduce = !push;
      end
      default: begin
        push = (tok_q == iee_pkg::TK_OPEN);
        reduce = !push;
      end
    endcase
    if (push && ocnt_q >= Depth) begin
      push = 1'b0; emit = 1'b1; estat = 3'(iee_pkg::ST_OVERFLOW);
    end
    if (reduce && vcnt_q < 2) begin
      reduce = 1'b0; emit = 1'b1; estat = 3'(iee_pkg::ST_MISSING);
    end
    if (reduce && top_q == 3'(iee_pkg::TK_DIV) && vb_q == '0) begin
      reduce = 1'b0; emit = 1'b1; estat = 3'(iee_pkg::ST_DIVZERO);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      iee_pkg::S_IDLE:
        if (in_valid_i) begin
          if (op_i == 3'(iee_pkg::TK_NUM)) begin
            if (vcnt_q >= Depth) state_d = iee_pkg::S_OUT;
          end else begin
            state_d = iee_pkg::S_DECIDE;
          end
        end
      iee_pkg::S_DECIDE:
        if (emit) state_d = iee_pkg::S_OUT;
        else if (reduce) state_d = iee_pkg::S_ALU;
        else state_d = iee_pkg::S_IDLE;
      iee_pkg::S_ALU:
        if (rsp.done) state_d = iee_pkg::S_FETCH;
      iee_pkg::S_FETCH:
        state_d = iee_pkg::S_DECIDE;
      iee_pkg::S_OUT:
        if (!out_stall_i) state_d = iee_pkg::S_IDLE;
      default: state_d = iee_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    ocnt_d    = ocnt_q;
    vcnt_d    = vcnt_q;
    res_d     = res_q;
    sts_d     = sts_q;
    push_o    = 1'b0;
    push_v    = 1'b0;
    wr_res    = 1'b0;
    ld_tok    = 1'b0;
    v_wdata   = number_value_i;
    req.start = 1'b0;
    req.code  = iee_pkg::token_e'(top_q);
    req.a     = va_q;
    req.b     = vb_q;
    case (state_q)
      iee_pkg::S_IDLE:
        if (in_valid_i) begin
          ld_tok = 1'b1;
          if (op_i == 3'(iee_pkg::TK_NUM)) begin
            if (vcnt_q >= Depth) begin
              res_d = '0; sts_d = 3'(iee_pkg::ST_OVERFLOW);
            end else begin
              push_v = 1'b1; vcnt_d = vcnt_q + 1'b1;
            end
          end
        end
      iee_pkg::S_DECIDE:
        if (emit) begin
          res_d = evalue; sts_d = estat;
        end else if (reduce) begin
          req.start = 1'b1;
          ocnt_d = ocnt_q - 1'b1;
        end else if (push) begin
          push_o = 1'b1; ocnt_d = ocnt_q + 1'b1;
        end else begin
          ocnt_d = ocnt_q - 1'b1;  // close meets its open
        end
      iee_pkg::S_ALU:
        if (rsp.done) begin
          vcnt_d = vcnt_q - 1'b1;
        end
      iee_pkg::S_FETCH:
        wr_res = 1'b1;
      iee_pkg::S_OUT:
        if (!out_stall_i) begin
          ocnt_d = iee_pkg::CntW'(1); vcnt_d = '0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iee_pkg::S_IDLE;
      ocnt_q  <= iee_pkg::CntW'(1);
      vcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ocnt_q  <= ocnt_d;
      vcnt_q  <= vcnt_d;
    end
  end

  assign in_stall_o     = (state_q != iee_pkg::S_IDLE);
  assign out_valid_o    = (state_q == iee_pkg::S_OUT);
  assign result_value_o = res_q;
  assign status_o       = sts_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q >= 1 && ocnt_q <= Depth && vcnt_q <= Depth)
    else $error("stack count out of range");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 3'(iee_pkg::ST_OK) |-> result_value_o == '0)
    else $error("error result not zero");
  a_out_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> ocnt_q == 1 && vcnt_q == 0)
    else $error("stacks not reset after result");
  a_alu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == iee_pkg::S_ALU)
    else $error("alu result outside reduction");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the infix expression evaluator
// Drives token words with random gaps, mirrors the two-stack evaluation in a
// scoreboard and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
class expr_scoreboard;
  logic [2:0]  op_stk [iee_pkg::StackDepth];
  int unsigned op_cnt;
  logic [31:0] val_stk [iee_pkg::StackDepth];
  int unsigned val_cnt;
  logic [31:0] want_value [$];
  logic [2:0]  want_status [$];
  int unsigned errors;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    op_stk[0] = iee_pkg::TK_END;
    op_cnt = 1;
    val_cnt = 0;
  endfunction

  function void post(logic [31:0] v, iee_pkg::status_e s);
    want_value.push_back(s == iee_pkg::ST_OK ? v : 32'd0);
    want_status.push_back(s);
    clear();
  endfunction

  // Mirrors the evaluator for one accepted token word.
  function void note_token(logic [2:0] tok, logic [31:0] num);
    logic [2:0] top;
    logic [31:0] a, b, r;
    logic push;
    if (tok == iee_pkg::TK_NUM) begin
      if (val_cnt >= iee_pkg::StackDepth) begin
        post(0, iee_pkg::ST_OVERFLOW);
        return;
      end
      val_stk[val_cnt++] = num;
      return;
    end
    forever begin
      top = op_stk[op_cnt - 1];
      push = 1'b0;
      if (top == iee_pkg::TK_END) begin
        if (tok == iee_pkg::TK_CLOSE) begin
          post(0, iee_pkg::ST_PAREN);
          return;
        end
        if (tok == iee_pkg::TK_END) begin
          if (val_cnt != 1) post(0, iee_pkg::ST_MISSING);
          else post(val_stk[0], iee_pkg::ST_OK);
          return;
        end
        push = 1'b1;
      end else if (top == iee_pkg::TK_OPEN) begin
        if (tok == iee_pkg::TK_CLOSE) begin
          op_cnt--;
          return;
        end
        if (tok == iee_pkg::TK_END) begin
          post(0, iee_pkg::ST_PAREN);
          return;
        end
        push = 1'b1;
      end else if (top == iee_pkg::TK_ADD || top == iee_pkg::TK_SUB) begin
        push = (tok == iee_pkg::TK_MUL || tok == iee_pkg::TK_DIV || tok == iee_pkg::TK_OPEN);
      end else begin
        push = (tok == iee_pkg::TK_OPEN);
      end
      if (push) begin
        if (op_cnt >= iee_pkg::StackDepth) begin
          post(0, iee_pkg::ST_OVERFLOW);
          return;
        end
        op_stk[op_cnt++] = tok;
        return;
      end
      op_cnt--;
      if (val_cnt < 2) begin
        post(0, iee_pkg::ST_MISSING);
        return;
      end
      b = val_stk[val_cnt - 1];
      a = val_stk[val_cnt - 2];
      case (top)
        iee_pkg::TK_ADD: r = a + b;
        iee_pkg::TK_SUB: r = a - b;
        iee_pkg::TK_MUL: r = a * b;
        default: begin
          if (b == 0) begin
            post(0, iee_pkg::ST_DIVZERO);
            return;
          end
          // The most negative value over minus one wraps back to itself.
          if (a == 32'h8000_0000 && b == 32'hffff_ffff) r = a;
          else r = $signed(a) / $signed(b);
        end
      endcase
      val_cnt--;
      val_stk[val_cnt - 1] = r;
    end
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(exp));
  endtask

  task check_result(logic [31:0] v, logic [2:0] s);
    if (want_status.size() == 0) begin
      report("unexpected word", v, 0);
      return;
    end
    if (v !== want_value[0]) report("result_value", v, want_value[0]);
    if (s !== want_status[0]) report("status", s, want_status[0]);
    void'(want_value.pop_front());
    void'(want_status.pop_front());
  endtask
endclass

module testbench;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         op_i;
  logic signed [31:0] number_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_o;

  expr_scoreboard board;
  int unsigned cycles;

  infix_expression_evaluator uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      3: return -$urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // The word stays on the port after acceptance; a gap or stop_input drops it.
  task automatic send_word(logic [2:0] tok, logic [31:0] num);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      op_i <= 3'($urandom);
      number_value_i <= $urandom;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= tok;
    number_value_i <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_token(tok, num);
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_binary(iee_pkg::token_e o, logic [31:0] a, logic [31:0] b);
    send_word(iee_pkg::TK_NUM, a);
    send_word(o, 0);
    send_word(iee_pkg::TK_NUM, b);
    send_word(iee_pkg::TK_END, 0);
  endtask

  // A random well-formed expression, with occasional nesting.
  task automatic send_expression(int unsigned depth);
    int unsigned n;
    n = $urandom_range(3, 1);
    for (int unsigned k = 0; k < n; k++) begin
      if (k != 0) send_word(3'($urandom_range(iee_pkg::TK_DIV, iee_pkg::TK_ADD)), 0);
      if (depth < 4 && $urandom_range(3) == 0) begin
        send_word(iee_pkg::TK_OPEN, 0);
        send_expression(depth + 1);
        send_word(iee_pkg::TK_CLOSE, 0);
      end else begin
        send_word(iee_pkg::TK_NUM, rand_num());
      end
    end
  endtask

  // Result side: random stall, check at each accepting edge.
  initial begin
    int unsigned g;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g != 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_result(result_value_o, status_o);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = iee_pkg::TK_NUM;
    number_value_i = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each operator, field extremes and every error but overflow.
    send_binary(iee_pkg::TK_ADD, 32'h7fff_ffff, 1);
    send_binary(iee_pkg::TK_SUB, 32'h8000_0000, 1);
    send_binary(iee_pkg::TK_MUL, 32'hffff_ffff, 32'h8000_0000);
    send_binary(iee_pkg::TK_DIV, -7, 2);
    send_binary(iee_pkg::TK_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_binary(iee_pkg::TK_DIV, 5, 0);
    send_word(iee_pkg::TK_CLOSE, 0);
    send_word(iee_pkg::TK_OPEN, 0);
    send_word(iee_pkg::TK_NUM, 3);
    send_word(iee_pkg::TK_END, 0);
    send_word(iee_pkg::TK_END, 0);
    send_word(iee_pkg::TK_NUM, 1);
    send_word(iee_pkg::TK_NUM, 2);
    send_word(iee_pkg::TK_END, 0);
    send_word(iee_pkg::TK_ADD, 0);
    send_word(iee_pkg::TK_END, 0);

    // Wait out every expected word before going on.
    stop_input();
    while (board.want_status.size() != 0) @(posedge clk_i);

    // Overflow of the value stack, then of the operator stack.
    for (int i = 0; i <= iee_pkg::StackDepth; i++) send_word(iee_pkg::TK_NUM, i);
    for (int i = 0; i < iee_pkg::StackDepth; i++) send_word(iee_pkg::TK_OPEN, 0);

    for (int unsigned i = 0; i < 95; i++) begin
      case ($urandom_range(9))
        0: for (int j = 0; j < 4; j++) send_word(3'($urandom), $urandom);
        1: begin
          send_expression(0);
          send_word(3'($urandom_range(iee_pkg::TK_END, iee_pkg::TK_CLOSE)), 0);
        end
        default: begin
          send_expression(0);
          send_word(iee_pkg::TK_END, 0);
        end
      endcase
    end
    stop_input();
    while (board.want_status.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.want_status.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

@@ infix_expression_evaluator.f @@
hdl/iee_pkg.sv
hdl/iee_alu.sv
hdl/infix_expression_evaluator.sv
bench/testbench.sv
